>>> rtl/hsfd_pkg.sv
`default_nettype none
package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [2:0] POS_TEMP_MSB = 3'd0;
    localparam logic [2:0] POS_TEMP_LSB = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_MSB  = 3'd3;
    localparam logic [2:0] POS_HUM_LSB  = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_CRC = 2'd1,
        STATUS_HUM_CRC  = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        temp_good;
        logic        hum_good;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/hsfd_front.sv
`default_nettype none
module hsfd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic            frame_start,
    output logic                 push,
    output hsfd_pkg::frame_t     frame
);
    import hsfd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_raw_reg, temp_raw_next;
    logic [15:0] hum_raw_reg, hum_raw_next;
    logic        temp_good_reg, temp_good_next;
    logic [2:0]  pos;

    always_comb
    begin
        pos            = (frame_start || pos_reg > POS_HUM_CRC) ? POS_TEMP_MSB : pos_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_raw_next  = temp_raw_reg;
        hum_raw_next   = hum_raw_reg;
        temp_good_next = temp_good_reg;
        push           = 1'b0;
        frame.temp_raw  = temp_raw_reg;
        frame.hum_raw   = hum_raw_reg;
        frame.temp_good = temp_good_reg;
        frame.hum_good  = (data_byte == crc_reg);
        if (accept)
        begin
            pos_next = pos + 3'd1;
            case (pos)
                POS_TEMP_MSB:
                begin
                    crc_next      = crc8_update(CRC_INIT, data_byte);
                    temp_raw_next = {data_byte, 8'h00};
                end
                POS_TEMP_LSB:
                begin
                    crc_next      = crc8_update(crc_reg, data_byte);
                    temp_raw_next = {temp_raw_reg[15:8], data_byte};
                end
                POS_TEMP_CRC:
                begin
                    temp_good_next = (data_byte == crc_reg);
                    crc_next       = CRC_INIT;
                end
                POS_HUM_MSB:
                begin
                    crc_next     = crc8_update(CRC_INIT, data_byte);
                    hum_raw_next = {data_byte, 8'h00};
                end
                POS_HUM_LSB:
                begin
                    crc_next     = crc8_update(crc_reg, data_byte);
                    hum_raw_next = {hum_raw_reg[15:8], data_byte};
                end
                default:
                begin
                    crc_next = CRC_INIT;
                    pos_next = POS_TEMP_MSB;
                    push     = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_TEMP_MSB;
            crc_reg       <= CRC_INIT;
            temp_raw_reg  <= '0;
            hum_raw_reg   <= '0;
            temp_good_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_raw_reg  <= temp_raw_next;
            hum_raw_reg   <= hum_raw_next;
            temp_good_reg <= temp_good_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/hsfd_queue.sv
`default_nettype none
module hsfd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire hsfd_pkg::frame_t     push_data,
    input  wire logic                 pop,
    output hsfd_pkg::frame_t          pop_data,
    output hsfd_pkg::queue_status_t   qstat
);
    import hsfd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + PTR_W'(1);
    endfunction

    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/hsfd_back.sv
`default_nettype none
module hsfd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 queue_empty,
    input  wire hsfd_pkg::frame_t     frame,
    output logic                      pop,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic signed [14:0]        temperature_centi,
    output logic [13:0]               humidity_centi,
    output logic [1:0]                status
);
    import hsfd_pkg::*;

    logic        s1_valid_reg;
    logic [30:0] temp_prod_reg;
    logic [29:0] hum_prod_reg;
    logic        temp_good_reg;
    logic        hum_good_reg;
    logic        out_valid_reg;
    logic [14:0] temp_reg, temp_next;
    logic [13:0] hum_reg, hum_next;
    status_t     status_reg, status_next;
    logic        out_advance, s1_load;
    logic [14:0] temp_q0, temp_q;
    logic [16:0] temp_rem;
    logic [13:0] hum_q0, hum_q;
    logic [16:0] hum_rem;

    assign out_advance = !out_valid_reg || !result_stall;
    assign s1_load     = !s1_valid_reg || out_advance;
    assign pop         = s1_load && !queue_empty;

    // divide by 65535: x = q0*65535 + (lo + q0), one correction step
    always_comb
    begin
        temp_q0  = temp_prod_reg[30:16];
        temp_rem = {1'b0, temp_prod_reg[15:0]} + {2'b00, temp_q0};
        temp_q   = temp_q0 + 15'((temp_rem >= FULL_SCALE) ? 1 : 0);
        hum_q0   = hum_prod_reg[29:16];
        hum_rem  = {1'b0, hum_prod_reg[15:0]} + {3'b000, hum_q0};
        hum_q    = hum_q0 + 14'((hum_rem >= FULL_SCALE) ? 1 : 0);
        if (!temp_good_reg)
        begin
            status_next = STATUS_TEMP_CRC;
            temp_next   = '0;
            hum_next    = '0;
        end
        else if (!hum_good_reg)
        begin
            status_next = STATUS_HUM_CRC;
            temp_next   = temp_q - TEMP_OFFSET;
            hum_next    = '0;
        end
        else
        begin
            status_next = STATUS_OK;
            temp_next   = temp_q - TEMP_OFFSET;
            hum_next    = hum_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            temp_prod_reg <= 31'(frame.temp_raw * TEMP_SCALE);
            hum_prod_reg  <= 30'(frame.hum_raw * HUM_SCALE);
            temp_good_reg <= frame.temp_good;
            hum_good_reg  <= frame.hum_good;
        end
        if (out_advance && s1_valid_reg)
        begin
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= !queue_empty;
            if (out_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign result_valid      = out_valid_reg;
    assign temperature_centi = signed'(temp_reg);
    assign humidity_centi    = hum_reg;
    assign status            = status_reg;

endmodule
`default_nettype wire

>>> rtl/humidity_sensor_frame_decoder_unit.sv
// temperature and humidity frame decoder
// byte channel: byte_valid / byte_stall carry data_byte and frame_start, one
//   response byte per item; frame_start marks byte 0 and restarts the frame
// result channel: result_valid / result_stall carry temperature_centi,
//   humidity_centi and status, one item per six-byte frame
// throughput: one byte per cycle unless stalled; the crc updates per byte
// path: after the sixth byte is accepted the frame passes through the frame
//   queue, multiply stage, divide-by-65535 and output register
// the front pushes each finished frame into a two-entry queue; byte_stall
//   rises only while that queue is full
// when result_stall is high the output register holds, the back pipeline
//   fills, then the queue fills and bytes are stalled
// reset: frame position to byte 0, crc to 0xff, queue and pipeline empty
`default_nettype none
module humidity_sensor_frame_decoder_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire logic [7:0]          data_byte,
    input  wire logic                frame_start,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic signed [14:0]       temperature_centi,
    output logic [13:0]              humidity_centi,
    output logic [1:0]               status
);
    import hsfd_pkg::*;

    logic          accept;
    logic          push;
    logic          pop;
    frame_t        push_frame;
    frame_t        pop_frame;
    queue_status_t qstat;

    assign byte_stall = qstat.full;
    assign accept     = byte_valid && !qstat.full;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .push        (push),
        .frame       (push_frame)
    );

    hsfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_frame),
        .pop       (pop),
        .pop_data  (pop_frame),
        .qstat     (qstat)
    );

    hsfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .queue_empty       (qstat.empty),
        .frame             (pop_frame),
        .pop               (pop),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .status            (status)
    );

endmodule
`default_nettype wire
